@@ design/foc_pkg.sv @@
// ----------------------------------------------------------------------------
// FOC transform package
// Shared types, fixed-point constants and the quarter-wave sine table builder.
// ----------------------------------------------------------------------------
`default_nettype none

package foc_pkg;

    localparam int SINE_DEPTH  = 1024;
    localparam int IDX_BITS    = 11;
    localparam int QSH         = 14;
    localparam int IDX_SHIFT   = 4;
    localparam int FULL_Q16    = 65536;

    typedef logic [14:0] t_sintab [0:SINE_DEPTH];

    typedef enum logic [1:0] {
        ROLE_NONE,
        ROLE_T0,
        ROLE_Y,
        ROLE_XY
    } t_role;

    typedef struct packed {
        logic signed [15:0] id;
        logic signed [15:0] iq;
        logic               ovf;
        logic signed [17:0] va;
        logic signed [17:0] vb;
        logic        [23:0] ibus;
    } t_rot;

    function automatic logic [14:0] f_sine_entry(input int unsigned i);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] r;
        x    = (64'd1686629713 * 64'(i)) / SINE_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (int k = 1; k <= 7; k++) begin
            term = (term * x2) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        r = (sum + 64'sd16384) >>> 15;
        if (r > 64'sd32767) begin
            r = 64'sd32767;
        end
        return r[14:0];
    endfunction

    function automatic t_sintab f_build_sintab();
        t_sintab t;
        for (int i = 0; i <= SINE_DEPTH; i++) begin
            t[i] = f_sine_entry(i);
        end
        return t;
    endfunction

endpackage

`default_nettype wire

@@ design/foc_transform_svpwm_core.sv @@
// ----------------------------------------------------------------------------
// FOC transform and SVPWM core
// Clarke/Park current transform, inverse Park and sector SVPWM duty generation.
// Path: input words pass registers r1-r5 in foc_rot, then r6-r11 in foc_svm.
// Throughput: one word per cycle unless stalled; stages hold on backpressure.
// Reset: synchronous active-low reset clears all stage valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module foc_transform_svpwm_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // angle, current_a, current_b, current_c, volt_d, volt_q, inv_bus
    input  wire logic [119:0] i_s_tdata,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // current_d, current_q, duty_a, duty_b, duty_c, sector_code, overmodulated
    output logic [87:0]       o_m_tdata
);
    import foc_pkg::*;

    t_rot rot;
    logic rot_vld;
    logic rot_rdy;

    foc_rot u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_s_tvalid),
        .o_rdy   (o_s_tready),
        .i_data  (i_s_tdata),
        .o_vld   (rot_vld),
        .i_rdy   (rot_rdy),
        .o_rot   (rot)
    );

    foc_svm u_svm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (rot_vld),
        .o_rdy   (rot_rdy),
        .i_rot   (rot),
        .o_vld   (o_m_tvalid),
        .i_rdy   (i_m_tready),
        .o_data  (o_m_tdata)
    );

endmodule

`default_nettype wire

@@ design/foc_rot.sv @@
// ----------------------------------------------------------------------------
// FOC rotation pipeline
// Sine lookup, Clarke, Park and inverse Park transforms over five stages.
// ----------------------------------------------------------------------------
`default_nettype none

module foc_rot (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_vld,
    output logic                    o_rdy,
    input  wire logic [119:0]       i_data,
    output logic                    o_vld,
    input  wire logic               i_rdy,
    output foc_pkg::t_rot           o_rot
);
    import foc_pkg::*;

    localparam t_sintab SINTAB = f_build_sintab();

    logic r_vld1, r_vld2, r_vld3, r_vld4, r_vld5;
    logic adv1, adv2, adv3, adv4, adv5;

    logic        [9:0]  r1_idx;
    logic        [1:0]  r1_quad;
    logic signed [15:0] r1_a, r1_vd, r1_vq;
    logic signed [16:0] r1_diff;
    logic        [23:0] r1_ibus;

    logic        [14:0] r2_lo, r2_hi;
    logic        [1:0]  r2_quad;
    logic signed [15:0] r2_a, r2_vd, r2_vq;
    logic signed [33:0] r2_prod;
    logic        [23:0] r2_ibus;

    logic signed [15:0] r3_s, r3_c, r3_a, r3_vd, r3_vq;
    logic signed [17:0] r3_ibeta;
    logic        [23:0] r3_ibus;
    logic signed [15:0] n3_s, n3_c;
    logic signed [33:0] n3_sum;

    logic signed [33:0] r4_ac, r4_bs, r4_bc, r4_as;
    logic signed [31:0] r4_dc, r4_qs, r4_ds, r4_qc;
    logic        [23:0] r4_ibus;

    t_rot               r5;
    logic signed [35:0] n5_d, n5_q;
    logic signed [33:0] n5_va, n5_vb;
    logic signed [20:0] n5_dr, n5_qr;
    logic               n5_ovf;

    logic signed [16:0] n1_b, n1_c;
    logic        [IDX_BITS-1:0] n2_hidx;

    assign adv5  = ~r_vld5 | i_rdy;
    assign adv4  = ~r_vld4 | adv5;
    assign adv3  = ~r_vld3 | adv4;
    assign adv2  = ~r_vld2 | adv3;
    assign adv1  = ~r_vld1 | adv2;
    assign o_rdy = adv1;
    assign o_vld = r_vld5;
    assign o_rot = r5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
        end else begin
            if (adv1) r_vld1 <= i_vld;
            if (adv2) r_vld2 <= r_vld1;
            if (adv3) r_vld3 <= r_vld2;
            if (adv4) r_vld4 <= r_vld3;
            if (adv5) r_vld5 <= r_vld4;
        end
    end

    assign n1_b    = 17'(signed'(i_data[47:32]));
    assign n1_c    = 17'(signed'(i_data[63:48]));
    assign n2_hidx = IDX_BITS'(SINE_DEPTH) - {1'b0, r1_idx};

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r1_idx  <= i_data[QSH-1:IDX_SHIFT];
            r1_quad <= i_data[15:14];
            r1_a    <= signed'(i_data[31:16]);
            r1_diff <= n1_b - n1_c;
            r1_vd   <= signed'(i_data[79:64]);
            r1_vq   <= signed'(i_data[95:80]);
            r1_ibus <= i_data[119:96];
        end
        if (adv2) begin
            r2_lo   <= SINTAB[{1'b0, r1_idx}];
            r2_hi   <= SINTAB[n2_hidx];
            r2_prod <= 34'(r1_diff) * 34'sd37837;
            r2_quad <= r1_quad;
            r2_a    <= r1_a;
            r2_vd   <= r1_vd;
            r2_vq   <= r1_vq;
            r2_ibus <= r1_ibus;
        end
    end

    always_comb begin
        case (r2_quad)
            2'd0: begin
                n3_s = 16'(signed'({1'b0, r2_lo}));
                n3_c = 16'(signed'({1'b0, r2_hi}));
            end
            2'd1: begin
                n3_s = 16'(signed'({1'b0, r2_hi}));
                n3_c = -16'(signed'({1'b0, r2_lo}));
            end
            2'd2: begin
                n3_s = -16'(signed'({1'b0, r2_lo}));
                n3_c = -16'(signed'({1'b0, r2_hi}));
            end
            default: begin
                n3_s = -16'(signed'({1'b0, r2_hi}));
                n3_c = 16'(signed'({1'b0, r2_lo}));
            end
        endcase
    end

    assign n3_sum = r2_prod + 34'sd32768;

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r3_s     <= n3_s;
            r3_c     <= n3_c;
            r3_ibeta <= n3_sum[33:16];
            r3_a     <= r2_a;
            r3_vd    <= r2_vd;
            r3_vq    <= r2_vq;
            r3_ibus  <= r2_ibus;
        end
        if (adv4) begin
            r4_ac   <= 34'(r3_a) * 34'(r3_c);
            r4_as   <= 34'(r3_a) * 34'(r3_s);
            r4_bs   <= 34'(r3_ibeta) * 34'(r3_s);
            r4_bc   <= 34'(r3_ibeta) * 34'(r3_c);
            r4_dc   <= r3_vd * r3_c;
            r4_qs   <= r3_vq * r3_s;
            r4_ds   <= r3_vd * r3_s;
            r4_qc   <= r3_vq * r3_c;
            r4_ibus <= r3_ibus;
        end
    end

    always_comb begin
        n5_d  = 36'(r4_ac) + 36'(r4_bs) + 36'sd16384;
        n5_q  = 36'(r4_bc) - 36'(r4_as) + 36'sd16384;
        n5_va = 34'(r4_dc) - 34'(r4_qs) + 34'sd16384;
        n5_vb = 34'(r4_ds) + 34'(r4_qc) + 34'sd16384;
        n5_dr = n5_d[35:15];
        n5_qr = n5_q[35:15];
        n5_ovf = 1'b0;
        if (n5_dr > 21'sd32767 || n5_dr < -21'sd32768) n5_ovf = 1'b1;
        if (n5_qr > 21'sd32767 || n5_qr < -21'sd32768) n5_ovf = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (adv5) begin
            if (n5_dr > 21'sd32767) begin
                r5.id <= 16'sh7fff;
            end else if (n5_dr < -21'sd32768) begin
                r5.id <= 16'sh8000;
            end else begin
                r5.id <= n5_dr[15:0];
            end
            if (n5_qr > 21'sd32767) begin
                r5.iq <= 16'sh7fff;
            end else if (n5_qr < -21'sd32768) begin
                r5.iq <= 16'sh8000;
            end else begin
                r5.iq <= n5_qr[15:0];
            end
            r5.ovf  <= n5_ovf;
            r5.va   <= n5_va[32:15];
            r5.vb   <= n5_vb[32:15];
            r5.ibus <= r4_ibus;
        end
    end

endmodule

`default_nettype wire

@@ design/foc_svm.sv @@
// ----------------------------------------------------------------------------
// FOC space-vector modulator
// Sector decode, projection scaling by bus reciprocal and duty saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module foc_svm (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_vld,
    output logic                    o_rdy,
    input  foc_pkg::t_rot           i_rot,
    output logic                    o_vld,
    input  wire logic               i_rdy,
    output logic [87:0]             o_data
);
    import foc_pkg::*;

    logic r_vld6, r_vld7, r_vld8, r_vld9, r_vld10, r_vld11;
    logic adv6, adv7, adv8, adv9, adv10, adv11;

    logic signed [32:0] n6_za, n6_zb, n6_zc, n6_zx, n6_zy;
    logic        [2:0]  n6_code;
    t_role              n6_ra, n6_rb, n6_rc;

    logic signed [32:0] r6_zx, r6_zy;
    logic signed [50:0] r7_mx, r7_my;
    logic signed [36:0] r8_mx, r8_my;
    logic signed [43:0] r9_hx, r9_hy;
    logic        [41:0] r9_lx, r9_ly;
    logic signed [39:0] r10_x, r10_y;
    logic signed [50:0] n8_x, n8_y;
    logic signed [63:0] n10_x, n10_y;

    logic        [2:0]  r6_code, r7_code, r8_code, r9_code, r10_code;
    t_role              r6_ra, r6_rb, r6_rc, r7_ra, r7_rb, r7_rc;
    t_role              r8_ra, r8_rb, r8_rc, r9_ra, r9_rb, r9_rc;
    t_role              r10_ra, r10_rb, r10_rc;
    logic signed [15:0] r6_id, r7_id, r8_id, r9_id, r10_id;
    logic signed [15:0] r6_iq, r7_iq, r8_iq, r9_iq, r10_iq;
    logic               r6_ovf, r7_ovf, r8_ovf, r9_ovf, r10_ovf;
    logic        [23:0] r6_ibus, r7_ibus, r8_ibus;

    logic signed [41:0] n11_t0, n11_sum, n11_ta, n11_tb, n11_tc;
    logic        [16:0] n11_da, n11_db, n11_dc;
    logic               n11_fa, n11_fb, n11_fc;
    logic        [87:0] r11_data;

    function automatic logic signed [41:0] f_time(input t_role role,
                                                   input logic signed [41:0] t0,
                                                   input logic signed [41:0] y,
                                                   input logic signed [41:0] xy);
        case (role)
            ROLE_T0: return t0;
            ROLE_Y:  return y + t0;
            ROLE_XY: return xy + t0;
            default: return 42'sd0;
        endcase
    endfunction

    function automatic logic [17:0] f_duty(input logic signed [41:0] t);
        logic signed [41:0] d;
        d = 42'(FULL_Q16) - t;
        if (d < 0) return {1'b1, 17'd0};
        if (d > 42'(FULL_Q16)) return {1'b1, 17'(FULL_Q16)};
        return {1'b0, d[16:0]};
    endfunction

    assign adv11 = ~r_vld11 | i_rdy;
    assign adv10 = ~r_vld10 | adv11;
    assign adv9  = ~r_vld9  | adv10;
    assign adv8  = ~r_vld8  | adv9;
    assign adv7  = ~r_vld7  | adv8;
    assign adv6  = ~r_vld6  | adv7;
    assign o_rdy = adv6;
    assign o_vld = r_vld11;
    assign o_data = r11_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld6  <= 1'b0;
            r_vld7  <= 1'b0;
            r_vld8  <= 1'b0;
            r_vld9  <= 1'b0;
            r_vld10 <= 1'b0;
            r_vld11 <= 1'b0;
        end else begin
            if (adv6)  r_vld6  <= i_vld;
            if (adv7)  r_vld7  <= r_vld6;
            if (adv8)  r_vld8  <= r_vld7;
            if (adv9)  r_vld9  <= r_vld8;
            if (adv10) r_vld10 <= r_vld9;
            if (adv11) r_vld11 <= r_vld10;
        end
    end

    always_comb begin
        n6_za   = 33'(i_rot.vb) * 33'sd16384;
        n6_zb   = 33'(i_rot.va) * 33'sd14189 - 33'(i_rot.vb) * 33'sd8192;
        n6_zc   = -(33'(i_rot.va) * 33'sd14189) - 33'(i_rot.vb) * 33'sd8192;
        n6_code = {n6_zc > 0, n6_zb > 0, n6_za > 0};
        case (n6_code)
            3'd3: begin
                n6_zx = n6_zb;  n6_zy = n6_za;
                n6_ra = ROLE_XY; n6_rb = ROLE_Y;  n6_rc = ROLE_T0;
            end
            3'd1: begin
                n6_zx = -n6_zb; n6_zy = -n6_zc;
                n6_ra = ROLE_Y;  n6_rb = ROLE_XY; n6_rc = ROLE_T0;
            end
            3'd5: begin
                n6_zx = n6_za;  n6_zy = n6_zc;
                n6_ra = ROLE_T0; n6_rb = ROLE_XY; n6_rc = ROLE_Y;
            end
            3'd4: begin
                n6_zx = -n6_za; n6_zy = -n6_zb;
                n6_ra = ROLE_T0; n6_rb = ROLE_Y;  n6_rc = ROLE_XY;
            end
            3'd6: begin
                n6_zx = n6_zc;  n6_zy = n6_zb;
                n6_ra = ROLE_Y;  n6_rb = ROLE_T0; n6_rc = ROLE_XY;
            end
            3'd2: begin
                n6_zx = -n6_zc; n6_zy = -n6_za;
                n6_ra = ROLE_XY; n6_rb = ROLE_T0; n6_rc = ROLE_Y;
            end
            default: begin
                n6_zx = 33'sd0; n6_zy = 33'sd0;
                n6_ra = ROLE_NONE; n6_rb = ROLE_NONE; n6_rc = ROLE_NONE;
            end
        endcase
    end

    assign n8_x  = r7_mx + 51'sd8192;
    assign n8_y  = r7_my + 51'sd8192;
    assign n10_x = (64'(r9_hx) <<< 18) + 64'(signed'({1'b0, r9_lx})) + 64'sd8388608;
    assign n10_y = (64'(r9_hy) <<< 18) + 64'(signed'({1'b0, r9_ly})) + 64'sd8388608;

    always_ff @(posedge i_clk) begin
        if (adv6) begin
            r6_zx <= n6_zx;   r6_zy <= n6_zy;   r6_code <= n6_code;
            r6_ra <= n6_ra;   r6_rb <= n6_rb;   r6_rc <= n6_rc;
            r6_id <= i_rot.id; r6_iq <= i_rot.iq; r6_ovf <= i_rot.ovf;
            r6_ibus <= i_rot.ibus;
        end
        if (adv7) begin
            r7_mx <= 51'(r6_zx) * 51'sd113512;
            r7_my <= 51'(r6_zy) * 51'sd113512;
            r7_code <= r6_code;
            r7_ra <= r6_ra; r7_rb <= r6_rb; r7_rc <= r6_rc;
            r7_id <= r6_id; r7_iq <= r6_iq; r7_ovf <= r6_ovf; r7_ibus <= r6_ibus;
        end
        if (adv8) begin
            r8_mx <= n8_x[50:14];
            r8_my <= n8_y[50:14];
            r8_code <= r7_code;
            r8_ra <= r7_ra; r8_rb <= r7_rb; r8_rc <= r7_rc;
            r8_id <= r7_id; r8_iq <= r7_iq; r8_ovf <= r7_ovf; r8_ibus <= r7_ibus;
        end
        if (adv9) begin
            r9_hx <= 44'(r8_mx[36:18]) * 44'(signed'({1'b0, r8_ibus}));
            r9_hy <= 44'(r8_my[36:18]) * 44'(signed'({1'b0, r8_ibus}));
            r9_lx <= 42'(r8_mx[17:0]) * 42'(r8_ibus);
            r9_ly <= 42'(r8_my[17:0]) * 42'(r8_ibus);
            r9_code <= r8_code;
            r9_ra <= r8_ra; r9_rb <= r8_rb; r9_rc <= r8_rc;
            r9_id <= r8_id; r9_iq <= r8_iq; r9_ovf <= r8_ovf;
        end
        if (adv10) begin
            r10_x <= n10_x[63:24];
            r10_y <= n10_y[63:24];
            r10_code <= r9_code;
            r10_ra <= r9_ra; r10_rb <= r9_rb; r10_rc <= r9_rc;
            r10_id <= r9_id; r10_iq <= r9_iq; r10_ovf <= r9_ovf;
        end
    end

    always_comb begin
        n11_sum = 42'(r10_x) + 42'(r10_y);
        n11_t0  = (42'(FULL_Q16) - n11_sum + 42'sd1) >>> 1;
        n11_ta  = f_time(r10_ra, n11_t0, 42'(r10_y), n11_sum);
        n11_tb  = f_time(r10_rb, n11_t0, 42'(r10_y), n11_sum);
        n11_tc  = f_time(r10_rc, n11_t0, 42'(r10_y), n11_sum);
        {n11_fa, n11_da} = f_duty(n11_ta);
        {n11_fb, n11_db} = f_duty(n11_tb);
        {n11_fc, n11_dc} = f_duty(n11_tc);
    end

    always_ff @(posedge i_clk) begin
        if (adv11) begin
            r11_data <= {1'b0, r10_ovf | n11_fa | n11_fb | n11_fc, r10_code,
                         n11_dc, n11_db, n11_da, r10_iq, r10_id};
        end
    end

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// FOC transform and SVPWM core testbench
// Drives random and corner-case control samples through the stream input with
// bursty gaps, stalls the output, and compares every output word field by
// field against a fixed-point prediction of the Clarke/Park/SVPWM step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;

    typedef struct packed {
        logic [23:0] inv_bus;
        logic [15:0] volt_q;
        logic [15:0] volt_d;
        logic [15:0] cur_c;
        logic [15:0] cur_b;
        logic [15:0] cur_a;
        logic [15:0] angle;
    } t_sample;

    typedef struct packed {
        logic        ovm;
        logic [2:0]  sector;
        logic [16:0] duty_c;
        logic [16:0] duty_b;
        logic [16:0] duty_a;
        logic [15:0] cur_q;
        logic [15:0] cur_d;
    } t_drive;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic         o_s_tready_q;
    logic [119:0] i_s_tdata;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [87:0]  o_m_tdata;

    t_sample      pending_q[$];
    t_drive       drive_q[$];
    logic [14:0]  sin_lut [0:1024];
    int           fail_cnt;
    int           word_cnt;
    int           ovm_cnt;
    int           burst_left;
    int           gap_left;
    int           stall_phase;
    bit           stim_done;

    foc_transform_svpwm_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    function automatic longint rshift_round(longint v, int n);
        longint w;
        w = v + (longint'(1) << (n - 1));
        return w >>> n;
    endfunction

    function automatic logic [14:0] sine_point(int i);
        longint unsigned x, x2, term;
        longint sum, r;
        x = (64'd1686629713 * longint'(i)) / 1024;
        x2 = (x * x) >> 30;
        term = x;
        sum = longint'(x);
        for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        r = (sum + 16384) >>> 15;
        if (r > 32767) begin
            r = 32767;
        end
        return r[14:0];
    endfunction

    function automatic longint phase_time(longint p, longint ibus);
        return rshift_round(rshift_round(p * 113512, 17) * ibus, 24);
    endfunction

    function automatic logic [16:0] clamp_duty(longint t, ref bit ovm);
        longint d;
        d = 65536 - t;
        if (d < 0) begin
            ovm = 1;
            d = 0;
        end else if (d > 65536) begin
            ovm = 1;
            d = 65536;
        end
        return d[16:0];
    endfunction

    function automatic logic [15:0] clamp_cur(longint v, ref bit ovm);
        if (v > 32767) begin
            ovm = 1;
            v = 32767;
        end else if (v < -32768) begin
            ovm = 1;
            v = -32768;
        end
        return v[15:0];
    endfunction

    function automatic t_drive predict_drive(t_sample s);
        t_drive o;
        bit ovm;
        int idx;
        longint lo, hi, sn, cs, ia, ib, ic, vd, vq, ibeta, va, vb, ibus;
        longint pa, pb, pc, ta, tb, tc, x, y, t0;
        logic [2:0] code;
        ovm = 0;
        idx = (int'(s.angle[13:0]) * 1024) >> 14;
        lo = sin_lut[idx];
        hi = sin_lut[1024 - idx];
        case (s.angle[15:14])
            2'd0: begin sn = lo; cs = hi; end
            2'd1: begin sn = hi; cs = -lo; end
            2'd2: begin sn = -lo; cs = -hi; end
            default: begin sn = -hi; cs = lo; end
        endcase
        ia = $signed(s.cur_a);
        ib = $signed(s.cur_b);
        ic = $signed(s.cur_c);
        vd = $signed(s.volt_d);
        vq = $signed(s.volt_q);
        ibus = s.inv_bus;
        ibeta = rshift_round((ib - ic) * 37837, 16);
        o.cur_d = clamp_cur(rshift_round(ia * cs + ibeta * sn, 15), ovm);
        o.cur_q = clamp_cur(rshift_round(ibeta * cs - ia * sn, 15), ovm);
        va = rshift_round(vd * cs - vq * sn, 15);
        vb = rshift_round(vd * sn + vq * cs, 15);
        pa = 131072 * vb;
        pb = 113512 * va - 65536 * vb;
        pc = -113512 * va - 65536 * vb;
        code = {pc > 0, pb > 0, pa > 0};
        ta = 0; tb = 0; tc = 0; x = 0; y = 0;
        case (code)
            3'd3: begin x = phase_time(pb, ibus); y = phase_time(pa, ibus); end
            3'd1: begin x = phase_time(-pb, ibus); y = phase_time(-pc, ibus); end
            3'd5: begin x = phase_time(pa, ibus); y = phase_time(pc, ibus); end
            3'd4: begin x = phase_time(-pa, ibus); y = phase_time(-pb, ibus); end
            3'd6: begin x = phase_time(pc, ibus); y = phase_time(pb, ibus); end
            3'd2: begin x = phase_time(-pc, ibus); y = phase_time(-pa, ibus); end
            default: ;
        endcase
        t0 = rshift_round(65536 - x - y, 1);
        case (code)
            3'd3: begin ta = x + y + t0; tb = y + t0; tc = t0; end
            3'd1: begin ta = y + t0; tb = x + y + t0; tc = t0; end
            3'd5: begin ta = t0; tb = x + y + t0; tc = y + t0; end
            3'd4: begin ta = t0; tb = y + t0; tc = x + y + t0; end
            3'd6: begin ta = y + t0; tb = t0; tc = x + y + t0; end
            3'd2: begin ta = x + y + t0; tb = t0; tc = y + t0; end
            default: ;
        endcase
        o.duty_a = clamp_duty(ta, ovm);
        o.duty_b = clamp_duty(tb, ovm);
        o.duty_c = clamp_duty(tc, ovm);
        o.sector = code;
        o.ovm = ovm;
        return o;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("MISMATCH word %0d %s: got %0d expected %0d", word_cnt, field, got, want);
        fail_cnt++;
    endtask

    task automatic add_sample(logic [15:0] ang, logic [15:0] a, logic [15:0] b,
                              logic [15:0] c, logic [15:0] vd, logic [15:0] vq,
                              logic [23:0] ibus);
        t_sample s;
        s = '{inv_bus: ibus, volt_q: vq, volt_d: vd, cur_c: c, cur_b: b,
              cur_a: a, angle: ang};
        pending_q.push_back(s);
    endtask

    function automatic logic [15:0] rand_s16();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(0, 512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        logic [23:0] ibus;
        for (int i = 0; i <= 1024; i++) begin
            sin_lut[i] = sine_point(i);
        end
        add_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'h400000);
        add_sample(16'hffff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 24'hffffff);
        add_sample(16'h4000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 24'hffffff);
        add_sample(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h0100, 16'h0000, 24'h000000);
        add_sample(16'hc000, 16'h8000, 16'h8000, 16'h7fff, 16'h0000, 16'h0100, 24'h000000);
        add_sample(16'h2000, 16'h1234, 16'h0000, 16'h0000, 16'h7fff, 16'h7fff, 24'hffffff);
        add_sample(16'h3fff, 16'hffff, 16'h0001, 16'hfffe, 16'h0000, 16'h0000, 24'hffffff);
        for (int k = 0; k < 12; k++) begin
            add_sample(16'(k * 5461 + 100), 16'h4000, 16'hc000, 16'h0000,
                       16'h0000, 16'h2000, 24'h001000);
        end
        add_sample(16'h1555, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 24'h000100);
        add_sample(16'h6aaa, 16'h0000, 16'h0000, 16'h0000, 16'hc000, 16'hc000, 24'h800000);
        for (int n = 0; n < 1380; n++) begin
            case ($urandom_range(0, 3))
                0: ibus = 24'($urandom);
                1: ibus = 24'($urandom_range(0, 4095));
                2: ibus = 24'($urandom_range(0, 65535));
                default: ibus = 24'($urandom_range(0, 1048575));
            endcase
            add_sample(16'($urandom), rand_s16(), rand_s16(), rand_s16(),
                       rand_s16(), rand_s16(), ibus);
        end
    end

    initial begin
        i_rst_n = 0;
        i_s_tvalid = 0;
        i_s_tdata = '0;
        i_m_tready = 0;
        fail_cnt = 0;
        word_cnt = 0;
        ovm_cnt = 0;
        burst_left = 0;
        gap_left = 0;
        stall_phase = 0;
        stim_done = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        wait (stim_done && drive_q.size() == 0);
        repeat (30) @(posedge i_clk);
        $display("Covered %0d output words, %0d with saturation", word_cnt, ovm_cnt);
        if (fail_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        o_s_tready_q <= o_s_tready;
    end

    // driver: hold the word until accepted, then advance in bursts with gaps
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!(i_s_tvalid && !o_s_tready_q)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_s_tvalid <= 0;
                end else if (pending_q.size() > 0) begin
                    i_s_tdata <= pending_q.pop_front();
                    i_s_tvalid <= 1;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_s_tvalid <= 0;
                    stim_done <= 1;
                end
            end
            stall_phase <= stall_phase + 1;
            if ((stall_phase % 600) < 150) begin
                i_m_tready <= 1;
            end else if ((stall_phase % 7) < 3) begin
                i_m_tready <= 0;
            end else begin
                i_m_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_drive got, want;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            drive_q.push_back(predict_drive(i_s_tdata));
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[86:0];
            if (drive_q.size() == 0) begin
                report_mismatch("unexpected word", 0, 0);
            end else begin
                want = drive_q.pop_front();
                if (got.cur_d !== want.cur_d)
                    report_mismatch("current_d", $signed(got.cur_d), $signed(want.cur_d));
                if (got.cur_q !== want.cur_q)
                    report_mismatch("current_q", $signed(got.cur_q), $signed(want.cur_q));
                if (got.duty_a !== want.duty_a)
                    report_mismatch("duty_a", got.duty_a, want.duty_a);
                if (got.duty_b !== want.duty_b)
                    report_mismatch("duty_b", got.duty_b, want.duty_b);
                if (got.duty_c !== want.duty_c)
                    report_mismatch("duty_c", got.duty_c, want.duty_c);
                if (got.sector !== want.sector)
                    report_mismatch("sector_code", got.sector, want.sector);
                if (got.ovm !== want.ovm)
                    report_mismatch("overmodulated", got.ovm, want.ovm);
                if (want.ovm)
                    ovm_cnt++;
            end
            word_cnt++;
        end
    end

endmodule

`default_nettype wire

@@ filelist.f @@
design/foc_pkg.sv
design/foc_rot.sv
design/foc_svm.sv
design/foc_transform_svpwm_core.sv
test/testbench.sv
